[src/mkc_pkg.sv]
// ----------------------------------------------------------------------------
// mkc_pkg
// Shared types, sizes, codes and key helpers for the MRU keyed lookup cache.
// ----------------------------------------------------------------------------
package mkc_pkg;

  localparam int CACHE_ENTRIES = 32;
  localparam int FILE_ID_BITS  = 16;

  localparam int POS_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t        CNT_FULL = cnt_t'(CACHE_ENTRIES);
  localparam logic [5:0]  OCC_FULL = 6'(CACHE_ENTRIES);

  typedef logic [1:0] status_t;
  localparam status_t STATUS_HIT      = 2'd0;
  localparam status_t STATUS_INSERTED = 2'd1;
  localparam status_t STATUS_FAILED   = 2'd2;

  localparam logic [1:0] AA_NONE = 2'd0;
  localparam logic [1:0] AA_SOME = 2'd1;
  localparam logic [1:0] AA_ALL  = 2'd2;

  typedef struct packed {
    logic [1:0]  family;
    logic        bold;
    logic        italic;
    logic        has_face_file;
    logic [15:0] face_file_id;
    logic [1:0]  aa_mode;
    logic        aa_flag;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        create_ok;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] entry_handle;
    logic [4:0] hit_position;
    logic       evicted;
    logic [5:0] occupancy;
  } rsp_t;

  // Normalized key: fields that do not take part in the compare are zero.
  typedef struct packed {
    logic [1:0]              family;
    logic                    bold;
    logic                    italic;
    logic                    has_file;
    logic [FILE_ID_BITS-1:0] file_id;
    logic                    aa;
    logic [31:0]             rgba;
  } key_t;

  typedef struct packed {
    key_t key;
    pos_t handle;
  } entry_t;

  function automatic key_t make_key(req_t r);
    key_t        k;
    logic [31:0] wide_id;
    k       = '0;
    wide_id = 32'(r.face_file_id);
    k.has_file = r.has_face_file;
    if (r.has_face_file) begin
      k.file_id = wide_id[FILE_ID_BITS-1:0];
    end else begin
      k.family = r.family;
      k.bold   = r.bold;
      k.italic = r.italic;
    end
    // mode 3 is treated as no antialiasing
    k.aa = (r.aa_mode == AA_ALL) || ((r.aa_mode == AA_SOME) && r.aa_flag);
    if (k.aa) begin
      k.rgba = {r.red, r.green, r.blue, r.alpha};
    end
    return k;
  endfunction

  function automatic logic [4:0] pos_to_out(pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[4:0];
  endfunction

  function automatic logic [5:0] cnt_to_out(cnt_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[5:0];
  endfunction

endpackage

[src/mru_keyed_lookup_cache.sv]
// ----------------------------------------------------------------------------
// mru_keyed_lookup_cache
// Fully associative lookup cache kept in most-recently-used order.
//
// Each request transaction carries a key (family/bold/italic or a face file
// id, plus the antialias decision and, when antialiased, an RGBA colour) and
// returns one response transaction. Entries live in a RAM with one write port
// and one registered read port, ordered by recency, position 0 newest. The
// sequencer reads one position per cycle and feeds it to a single compare
// unit; on a hit at position p, or on an insertion at position p, it then
// moves entries p-1..0 down by one position, one per cycle, and writes the
// hit or new entry at the front. On a full cache the tail slot is
// overwritten. The request side stalls until the result is handed to the
// output register; the response sits there, so a new request is taken
// while it waits to be taken.
// On a full cache the tail is evicted and its handle goes to the new entry;
// before that, the k-th insertion gets handle k-1. No clearing pass: only
// positions below the fill count are ever used.
// ----------------------------------------------------------------------------
module mru_keyed_lookup_cache (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mkc_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mkc_pkg::rsp_t rsp_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request
  localparam logic [2:0] ST_SCAN  = 3'd1;  // compare one position per cycle
  localparam logic [2:0] ST_MISS  = 3'd2;  // decide insert or fail
  localparam logic [2:0] ST_SHIFT = 3'd3;  // move entries down one position
  localparam logic [2:0] ST_FRONT = 3'd4;  // write position 0
  localparam logic [2:0] ST_DONE  = 3'd5;  // hand result to output register

  logic [2:0]        state, state_next;
  mkc_pkg::cnt_t     count, count_next;
  mkc_pkg::pos_t     idx, idx_next;       // scan position of rdata
  mkc_pkg::pos_t     sj, sj_next;         // next shift write target
  mkc_pkg::key_t     qkey, qkey_next;
  logic              create_ok, create_ok_next;
  mkc_pkg::entry_t   front, front_next;   // entry bound for position 0
  mkc_pkg::pos_t     tail_handle, tail_handle_next;
  mkc_pkg::status_t  status, status_next;
  mkc_pkg::pos_t     handle, handle_next;
  mkc_pkg::pos_t     hitpos, hitpos_next;
  logic              evicted, evicted_next;
  logic              rsp_valid_next;
  mkc_pkg::rsp_t     rsp_data_next;

  logic              ram_we;
  mkc_pkg::pos_t     ram_waddr;
  mkc_pkg::entry_t   ram_wdata;
  mkc_pkg::pos_t     ram_raddr;
  mkc_pkg::entry_t   ram_rdata;

  logic              match;
  logic              full;
  mkc_pkg::pos_t     ins_pos;
  mkc_pkg::pos_t     ins_handle;

  mkc_key_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mkc_key_cmp u_cmp (
    .query (qkey),
    .entry (ram_rdata.key),
    .match (match)
  );

  assign req_stall = (state != ST_IDLE);
  assign full      = (count == mkc_pkg::CNT_FULL);

  // Insertion point: the tail slot when full, else one past the last entry.
  assign ins_pos    = full ? mkc_pkg::pos_t'(count - mkc_pkg::cnt_t'(1))
                           : mkc_pkg::pos_t'(count);
  assign ins_handle = full ? tail_handle : mkc_pkg::pos_t'(count);

  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    sj_next          = sj;
    qkey_next        = qkey;
    create_ok_next   = create_ok;
    front_next       = front;
    tail_handle_next = tail_handle;
    status_next      = status;
    handle_next      = handle;
    hitpos_next      = hitpos;
    evicted_next     = evicted;
    rsp_data_next    = rsp_data;
    rsp_valid_next   = rsp_valid && rsp_stall;
    ram_we           = 1'b0;
    ram_waddr        = sj;
    ram_wdata        = ram_rdata;
    ram_raddr        = '0;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          qkey_next      = mkc_pkg::make_key(req_data);
          create_ok_next = req_data.create_ok;
          idx_next       = '0;
          status_next    = mkc_pkg::STATUS_HIT;
          handle_next    = '0;
          hitpos_next    = '0;
          evicted_next   = 1'b0;
          ram_raddr      = '0;
          state_next     = (count == '0) ? ST_MISS : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (match) begin
          status_next = mkc_pkg::STATUS_HIT;
          handle_next = ram_rdata.handle;
          hitpos_next = idx;
          front_next  = ram_rdata;
          if (idx == '0) begin
            state_next = ST_FRONT;
          end else begin
            ram_raddr  = idx - mkc_pkg::pos_t'(1);
            sj_next    = idx;
            state_next = ST_SHIFT;
          end
        end else if ((mkc_pkg::cnt_t'(idx) + mkc_pkg::cnt_t'(1)) == count) begin
          // last valid position; when full this is the tail
          tail_handle_next = ram_rdata.handle;
          state_next       = ST_MISS;
        end else begin
          ram_raddr = idx + mkc_pkg::pos_t'(1);
          idx_next  = idx + mkc_pkg::pos_t'(1);
        end
      end

      ST_MISS: begin
        if (!create_ok) begin
          status_next = mkc_pkg::STATUS_FAILED;
          state_next  = ST_DONE;
        end else begin
          status_next       = mkc_pkg::STATUS_INSERTED;
          front_next.key    = qkey;
          front_next.handle = ins_handle;
          handle_next       = ins_handle;
          evicted_next      = full;
          if (!full) begin
            count_next = count + mkc_pkg::cnt_t'(1);
          end
          if (ins_pos == '0) begin
            state_next = ST_FRONT;
          end else begin
            ram_raddr  = ins_pos - mkc_pkg::pos_t'(1);
            sj_next    = ins_pos;
            state_next = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // rdata holds position sj-1; read of sj-2 overlaps the write
        ram_we    = 1'b1;
        ram_waddr = sj;
        ram_wdata = ram_rdata;
        if (sj == mkc_pkg::pos_t'(1)) begin
          state_next = ST_FRONT;
        end else begin
          ram_raddr = sj - mkc_pkg::pos_t'(2);
          sj_next   = sj - mkc_pkg::pos_t'(1);
        end
      end

      ST_FRONT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = front;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next              = 1'b1;
          rsp_data_next.status        = status;
          rsp_data_next.entry_handle  = mkc_pkg::pos_to_out(handle);
          rsp_data_next.hit_position  = mkc_pkg::pos_to_out(hitpos);
          rsp_data_next.evicted       = evicted;
          rsp_data_next.occupancy     = mkc_pkg::cnt_to_out(count);
          state_next                  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    idx         <= idx_next;
    sj          <= sj_next;
    qkey        <= qkey_next;
    create_ok   <= create_ok_next;
    front       <= front_next;
    tail_handle <= tail_handle_next;
    status      <= status_next;
    handle      <= handle_next;
    hitpos      <= hitpos_next;
    evicted     <= evicted_next;
    rsp_data    <= rsp_data_next;
  end

endmodule

[src/mkc_key_ram.sv]
// ----------------------------------------------------------------------------
// mkc_key_ram
// Entry store ordered by recency: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mkc_key_ram (
  input  logic            clk,
  input  logic            we,
  input  mkc_pkg::pos_t   waddr,
  input  mkc_pkg::entry_t wdata,
  input  mkc_pkg::pos_t   raddr,
  output mkc_pkg::entry_t rdata
);

  mkc_pkg::entry_t mem [mkc_pkg::CACHE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mkc_key_cmp.sv]
// ----------------------------------------------------------------------------
// mkc_key_cmp
// Key compare unit: identity (family triple or face file), antialias, colour.
// ----------------------------------------------------------------------------
module mkc_key_cmp (
  input  mkc_pkg::key_t query,
  input  mkc_pkg::key_t entry,
  output logic          match
);

  logic ident;

  always_comb begin
    if (!query.has_file && !entry.has_file) begin
      ident = (query.family == entry.family) && (query.bold == entry.bold) &&
              (query.italic == entry.italic);
    end else if (query.has_file && entry.has_file) begin
      ident = (query.file_id == entry.file_id);
    end else begin
      ident = 1'b0;
    end
    // colour only matters for antialiased keys
    match = ident && (query.aa == entry.aa) &&
            (!query.aa || (query.rgba == entry.rgba));
  end

endmodule

[src/mkc_checker.sv]
// ----------------------------------------------------------------------------
// mkc_checker
// Port-level checks for the MRU keyed lookup cache, bound to the top level.
// ----------------------------------------------------------------------------
module mkc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input mkc_pkg::rsp_t rsp_data
);

  // a held response keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  // one request at a time: taking one closes the request side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request side open right after a transaction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == mkc_pkg::STATUS_HIT) |-> !rsp_data.evicted)
    else $error("hit reported an eviction");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == mkc_pkg::STATUS_FAILED) |->
      (rsp_data.entry_handle == '0) && (rsp_data.hit_position == '0) &&
      !rsp_data.evicted)
    else $error("failed miss carries handle, position or eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.evicted |->
      (rsp_data.occupancy == mkc_pkg::OCC_FULL) &&
      (rsp_data.status == mkc_pkg::STATUS_INSERTED))
    else $error("eviction without a full cache");

endmodule

bind mru_keyed_lookup_cache mkc_checker u_mkc_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MRU keyed lookup cache.
//
// A short directed table walks the corner cases (failed create on an empty
// cache, ignored fields, family 3, unknown antialias mode, face-file keys,
// colour compare only under antialiasing). A random phase follows. It draws
// most requests from a pool of recently used keys larger than the cache, so
// the run sees hits at deep positions, a full cache and tail evictions. Each
// accepted response is compared field by field with a typed row or the in-bench MRU model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // --------------------------------------------------------------------------
  // Run sizing
  // --------------------------------------------------------------------------
  localparam int RANDOM_ITEMS = 750;
  localparam int POOL_DEPTH   = 48;       // more keys than entries -> evictions
  localparam int DRAIN_CYCLES = 2 * mkc_pkg::CACHE_ENTRIES + 20;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int HOLD_AT      = 200;      // transaction count that starts the hold
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_FROM   = 400;      // no idling on either side in here
  localparam int QUIET_TO     = 520;

  // Field values with a meaning; mode 3 has no name in the package
  localparam logic [1:0] AA_UNKNOWN  = 2'd3;
  localparam logic [1:0] FAM_ARIAL   = 2'd0;
  localparam logic [1:0] FAM_COURIER = 2'd1;
  localparam logic [1:0] FAM_TIMES   = 2'd2;
  localparam logic [1:0] FAM_UNDEF   = 2'd3;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  mkc_pkg::req_t  req_data;
  logic           rsp_valid;
  logic           rsp_stall;
  mkc_pkg::rsp_t  rsp_data;

  mru_keyed_lookup_cache dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // MRU model of the cache: normalized key plus handle, position 0 newest.
  // Fields that take no part in the compare are stored as zero, so a plain
  // equality on the normalized key is the whole match rule.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  family;
    logic        bold;
    logic        italic;
    logic        has_file;
    logic [15:0] file_id;
    logic        aa;
    logic [31:0] rgba;
  } font_key_t;

  typedef struct packed {
    font_key_t  key;
    logic [4:0] handle;
  } font_slot_t;

  font_slot_t mru_slots [mkc_pkg::CACHE_ENTRIES];
  int         slot_count;

  mkc_pkg::rsp_t font_results_due [$];

  function automatic mkc_pkg::rsp_t lookup_font(mkc_pkg::req_t r);
    font_key_t     k;
    font_slot_t    s;
    mkc_pkg::rsp_t o;
    int            hit_at;
    k        = '0;
    o        = '0;
    hit_at   = -1;
    k.has_file = r.has_face_file;
    if (r.has_face_file) begin
      k.file_id = r.face_file_id;
    end else begin
      k.family = r.family;
      k.bold   = r.bold;
      k.italic = r.italic;
    end
    // mode 3 falls through to "no antialiasing"
    k.aa = (r.aa_mode == mkc_pkg::AA_ALL) ||
           ((r.aa_mode == mkc_pkg::AA_SOME) && r.aa_flag);
    if (k.aa) begin
      k.rgba = {r.red, r.green, r.blue, r.alpha};
    end

    for (int i = 0; i < slot_count; i++) begin
      if (hit_at < 0 && mru_slots[i].key == k) hit_at = i;
    end

    if (hit_at >= 0) begin
      s              = mru_slots[hit_at];
      o.status       = mkc_pkg::STATUS_HIT;
      o.entry_handle = s.handle;
      o.hit_position = 5'(hit_at);
      for (int j = hit_at; j > 0; j--) mru_slots[j] = mru_slots[j-1];
      mru_slots[0] = s;
    end else if (r.create_ok) begin
      o.status = mkc_pkg::STATUS_INSERTED;
      if (slot_count == mkc_pkg::CACHE_ENTRIES) begin
        // full: drop the tail and recycle its handle
        s.handle   = mru_slots[mkc_pkg::CACHE_ENTRIES-1].handle;
        slot_count = slot_count - 1;
        o.evicted  = 1'b1;
      end else begin
        s.handle = 5'(slot_count);
      end
      s.key          = k;
      o.entry_handle = s.handle;
      for (int j = slot_count; j > 0; j--) mru_slots[j] = mru_slots[j-1];
      mru_slots[0] = s;
      slot_count   = slot_count + 1;
    end else begin
      o.status = mkc_pkg::STATUS_FAILED;
    end
    o.occupancy = 6'(slot_count);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic mkc_pkg::req_t mk_req(logic [1:0] fam, logic bo, logic it, logic hf,
                                           logic [15:0] fid, logic [1:0] mode, logic flag,
                                           logic [31:0] rgba, logic create);
    mkc_pkg::req_t r;
    r.family        = fam;
    r.bold          = bo;
    r.italic        = it;
    r.has_face_file = hf;
    r.face_file_id  = fid;
    r.aa_mode       = mode;
    r.aa_flag       = flag;
    {r.red, r.green, r.blue, r.alpha} = rgba;
    r.create_ok     = create;
    return r;
  endfunction

  function automatic mkc_pkg::rsp_t mk_rsp(mkc_pkg::status_t st, logic [4:0] hnd,
                                           logic [4:0] pos, logic ev, logic [5:0] occ);
    mkc_pkg::rsp_t o;
    o.status       = st;
    o.entry_handle = hnd;
    o.hit_position = pos;
    o.evicted      = ev;
    o.occupancy    = occ;
    return o;
  endfunction

  // every bit of the request random; family 3 and mode 3 come up too
  function automatic mkc_pkg::req_t fresh_request();
    logic [63:0]   raw;
    mkc_pkg::req_t r;
    raw = {$urandom, $urandom};
    r   = raw[$bits(mkc_pkg::req_t)-1:0];
    r.has_face_file = ($urandom_range(99) < 40);
    return r;
  endfunction

  mkc_pkg::req_t font_pool [POOL_DEPTH];

  // Mostly revisits pooled keys (hits, reordering) with the don't-care fields
  // scrambled; the rest are new keys that also refresh the pool.
  function automatic mkc_pkg::req_t random_request();
    mkc_pkg::req_t r;
    logic          aa;
    if ($urandom_range(99) < 65) begin
      r = font_pool[$urandom_range(POOL_DEPTH-1)];
      if (r.has_face_file) {r.family, r.bold, r.italic} = 4'($urandom);
      else r.face_file_id = 16'($urandom);
      aa = (r.aa_mode == mkc_pkg::AA_ALL) ||
           ((r.aa_mode == mkc_pkg::AA_SOME) && r.aa_flag);
      if (!aa) begin
        {r.red, r.green, r.blue, r.alpha} = $urandom;
        if (r.aa_mode != mkc_pkg::AA_SOME) r.aa_flag = 1'($urandom);
      end else begin
        if (r.aa_mode == mkc_pkg::AA_ALL) r.aa_flag = 1'($urandom);
        // near miss: one colour bit off
        if ($urandom_range(9) == 0) r.alpha ^= 8'h01 << $urandom_range(7);
      end
    end else begin
      r = fresh_request();
      font_pool[$urandom_range(POOL_DEPTH-1)] = r;
    end
    r.create_ok = ($urandom_range(99) < 85);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idling policy shared by both sides
  // --------------------------------------------------------------------------
  int accepted_reqs;
  int cycle_count;
  int fail_count;

  function automatic logic idle_roll();
    if (accepted_reqs >= QUIET_FROM && accepted_reqs < QUIET_TO) return 1'b0;
    return ($urandom_range(99) < 26);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid stays up across back-to-back transactions; the
  // expectation is queued at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_request(mkc_pkg::req_t r, logic typed, mkc_pkg::rsp_t want);
    mkc_pkg::rsp_t predicted;
    while (idle_roll()) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    accepted_reqs = accepted_reqs + 1;
    predicted = lookup_font(r);
    // hand-written rows still advance the model state
    font_results_due.push_back(typed ? want : predicted);
  endtask

  typedef struct packed {
    mkc_pkg::req_t rq;
    logic          typed;
    mkc_pkg::rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // --------------------------------------------------------------------------
  // Response side: random stall, one long hold once the traffic is going, and
  // a stretch without stalls. The hold is counted here so the sender keeps
  // pushing and backs up into req_stall.
  // --------------------------------------------------------------------------
  initial begin
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_reqs >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= idle_roll();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response checker
  // --------------------------------------------------------------------------
  int n_hits, n_inserts, n_refused, n_evicts, deepest_hit;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin
    mkc_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (font_results_due.size() == 0) begin
        $error("response with nothing outstanding: %h", rsp_data);
        fail_count = fail_count + 1;
      end else begin
        want = font_results_due.pop_front();
        check_field("status",       32'(want.status),       32'(rsp_data.status));
        check_field("entry_handle", 32'(want.entry_handle), 32'(rsp_data.entry_handle));
        check_field("hit_position", 32'(want.hit_position), 32'(rsp_data.hit_position));
        check_field("evicted",      32'(want.evicted),      32'(rsp_data.evicted));
        check_field("occupancy",    32'(want.occupancy),    32'(rsp_data.occupancy));
      end
      case (rsp_data.status)
        mkc_pkg::STATUS_HIT: begin
          n_hits = n_hits + 1;
          if (int'(rsp_data.hit_position) > deepest_hit) begin
            deepest_hit = int'(rsp_data.hit_position);
          end
        end
        mkc_pkg::STATUS_INSERTED: n_inserts = n_inserts + 1;
        default:                  n_refused = n_refused + 1;
      endcase
      if (rsp_data.evicted) n_evicts = n_evicts + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, font_results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    accepted_reqs = 0;
    cycle_count   = 0;
    fail_count    = 0;
    slot_count    = 0;
    n_hits        = 0;
    n_inserts     = 0;
    n_refused     = 0;
    n_evicts      = 0;
    deepest_hit   = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;

    foreach (font_pool[i]) font_pool[i] = fresh_request();

    // Directed rows. Expected values are typed in where they are obvious;
    // order after row 9 is handles 4,3,2,1,0 from the front.
    // refused create on an empty cache
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 0, 0, 16'h0000, mkc_pkg::AA_NONE, 0, 32'h0, 0),
                         1'b1, mk_rsp(mkc_pkg::STATUS_FAILED, 0, 0, 0, 0)});
    // first insert; file id and colour are don't-care here
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 0, 0, 16'h1234, mkc_pkg::AA_NONE, 0,
                                32'hDEADBEEF, 1),
                         1'b1, mk_rsp(mkc_pkg::STATUS_INSERTED, 0, 0, 0, 1)});
    // mode "some" without the flag is not antialiased -> same key
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 0, 0, 16'hFFFF, mkc_pkg::AA_SOME, 0, 32'h0, 1),
                         1'b1, mk_rsp(mkc_pkg::STATUS_HIT, 0, 0, 0, 1)});
    // family 3 with unknown antialias mode
    dir_rows.push_back('{mk_req(FAM_UNDEF, 1, 1, 0, 16'h0000, AA_UNKNOWN, 1, 32'hFFFFFFFF, 1),
                         1'b1, mk_rsp(mkc_pkg::STATUS_INSERTED, 1, 0, 0, 2)});
    dir_rows.push_back('{mk_req(FAM_UNDEF, 1, 1, 0, 16'h0000, mkc_pkg::AA_NONE, 0, 32'h0, 1),
                         1'b1, mk_rsp(mkc_pkg::STATUS_HIT, 1, 0, 0, 2)});
    // face file key, family bits ignored, full colour
    dir_rows.push_back('{mk_req(FAM_TIMES, 1, 0, 1, 16'hFFFF, mkc_pkg::AA_ALL, 0,
                                32'hFFFFFFFF, 1),
                         1'b1, mk_rsp(mkc_pkg::STATUS_INSERTED, 2, 0, 0, 3)});
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 1, 1, 16'hFFFF, mkc_pkg::AA_SOME, 1,
                                32'hFFFFFFFF, 0),
                         1'b1, mk_rsp(mkc_pkg::STATUS_HIT, 2, 0, 0, 3)});
    // same file, other colour -> new entry
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 0, 1, 16'hFFFF, mkc_pkg::AA_ALL, 0,
                                32'h00000000, 1),
                         1'b1, mk_rsp(mkc_pkg::STATUS_INSERTED, 3, 0, 0, 4)});
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 0, 1, 16'h0000, mkc_pkg::AA_SOME, 0,
                                32'hFFFFFFFF, 1),
                         1'b1, mk_rsp(mkc_pkg::STATUS_INSERTED, 4, 0, 0, 5)});
    // oldest entry, found at the tail
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 0, 0, 16'h0000, mkc_pkg::AA_NONE, 0, 32'h0, 0),
                         1'b1, mk_rsp(mkc_pkg::STATUS_HIT, 0, 4, 0, 5)});
    // the rest go through the model
    dir_rows.push_back('{mk_req(FAM_ARIAL, 0, 0, 1, 16'h0000, mkc_pkg::AA_NONE, 1,
                                32'h55AA55AA, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FAM_COURIER, 1, 0, 0, 16'h0000, mkc_pkg::AA_SOME, 1,
                                32'h01020304, 1),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FAM_COURIER, 1, 0, 0, 16'h0000, mkc_pkg::AA_SOME, 1,
                                32'h01020305, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FAM_COURIER, 1, 0, 0, 16'hABCD, mkc_pkg::AA_ALL, 0,
                                32'h01020304, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FAM_COURIER, 1, 0, 0, 16'h0000, mkc_pkg::AA_NONE, 0,
                                32'h01020304, 1),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FAM_TIMES, 0, 1, 1, 16'h8000, mkc_pkg::AA_NONE, 0, 32'h0, 1),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FAM_TIMES, 0, 1, 1, 16'h8001, mkc_pkg::AA_NONE, 0, 32'h0, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk_req(FAM_TIMES, 0, 1, 0, 16'h8000, mkc_pkg::AA_NONE, 0, 32'h0, 0),
                         1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    repeat (RANDOM_ITEMS) send_request(random_request(), 1'b0, '0);
    req_valid <= 1'b0;

    while (font_results_due.size() != 0) @(posedge clk);
    // catch any stray response after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d lookups: %0d hits (deepest at position %0d), %0d inserts, %0d evictions,",
             accepted_reqs, n_hits, deepest_hit, n_inserts, n_evicts);
    $display("%0d refused creates, %0d field mismatches, %0d cycles",
             n_refused, fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
